// ----- design/itsch_pkg.sv -----
package itsch_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONEDUE  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_YIELDSET = 3'd6;
  localparam logic [STATUS_W-1:0] ST_RESUMED  = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] last_run;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_FIND,
    S_SHIFT,
    S_MOD,
    S_WALK,
    S_FIN,
    S_REPLY
  } state_t;

endpackage

// ----- design/itsch_ram.sv -----
module itsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/interval_task_scheduler.sv -----
// interval task scheduler: a table of up to MAX_TASKS periodic tasks
//
// input channel (in_valid/in_ready) carries one beat per command: kind,
// task_id, interval and now. output channel (out_valid/out_ready) carries
// result beats: status, result_id and last, where last marks the final
// beat caused by one command. unknown kinds are taken and dropped.
//
// one command at a time, in_ready high only while idle. an add, or a tick
// on an empty table, registers its beat in S_ADD or S_REPLY once the
// result register is free. delete, yield and resume scan the task memory
// one entry a cycle, and the beat is registered from S_REPLY; a delete
// that hits first compacts the table, one entry moved a cycle. a tick
// reduces the round-robin start by repeated subtraction of task_count in
// S_MOD, needed only after deletes, then walks the table one entry a cycle
// while the result register is not stuck, stopping after a due task whose
// yield flag is set. the task memory has a registered read.
// reset clears the task count, the start pointer, the id counter and all
// yield flags; the task memory needs no clearing. a stalled receiver holds
// the result register and the walk waits on it; nothing is dropped.
module interval_task_scheduler #(
  parameter int MAX_TASKS = itsch_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [itsch_pkg::KIND_W-1:0]   kind,
  input  logic [itsch_pkg::ID_W-1:0]     task_id,
  input  logic [itsch_pkg::TIME_W-1:0]   interval,
  input  logic [itsch_pkg::TIME_W-1:0]   now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [itsch_pkg::STATUS_W-1:0] status,
  output logic [itsch_pkg::ID_W-1:0]     result_id,
  output logic                           last
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ENTRY_W = $bits(itsch_pkg::entry_t);

  // control state
  itsch_pkg::state_t state, state_next;
  logic [CNT_W-1:0]     task_count, task_count_next;
  logic [IDX_W-1:0]     start_index, start_index_next;
  logic [itsch_pkg::ID_W-1:0] id_counter, id_counter_next;
  logic [MAX_TASKS-1:0] yield_flag, yield_flag_next;
  logic                 pend, pend_next;
  logic                 held_valid, held_valid_next;

  // working registers
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] rp, rp_next;
  logic [IDX_W-1:0] chk, chk_next;
  logic [IDX_W-1:0] wp, wp_next;
  logic [itsch_pkg::ID_W-1:0]     held_id, held_id_next;
  logic [itsch_pkg::STATUS_W-1:0] rep_status, rep_status_next;
  logic [itsch_pkg::ID_W-1:0]     rep_id, rep_id_next;
  logic [itsch_pkg::KIND_W-1:0]   cur_kind, cur_kind_next;
  logic [itsch_pkg::ID_W-1:0]     cur_tid, cur_tid_next;
  logic [itsch_pkg::TIME_W-1:0]   cur_ival, cur_ival_next;
  logic [itsch_pkg::TIME_W-1:0]   cur_now, cur_now_next;

  // task memory port
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  itsch_pkg::entry_t    ram_wdata, ram_q;

  // result beat request
  logic                           emit;
  logic [itsch_pkg::STATUS_W-1:0] emit_status;
  logic [itsch_pkg::ID_W-1:0]     emit_id;
  logic                           emit_last;
  logic                           out_free;

  // walk helpers
  logic                 full, match, due, hit, stall, stop;
  logic [MAX_TASKS-1:0] yield_shift;
  logic [IDX_W-1:0]     s_adj;

  assign out_free = !out_valid || out_ready;
  assign full = (task_count == CNT_W'(MAX_TASKS));
  assign yield_shift = yield_flag >> 1;

  // next position in round-robin order over n live entries
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] xp;
    xp = CNT_W'(x) + CNT_W'(1);
    return (xp == n) ? '0 : x + IDX_W'(1);
  endfunction

  itsch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_task_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // id compare for delete, yield and resume; resume wants the flag set
  assign match = pend && (ram_q.id == cur_tid) &&
                 ((cur_kind != itsch_pkg::KIND_RESUME) || yield_flag[chk]);
  // wrapping elapsed time against the period
  assign due   = (cur_now - ram_q.last_run) >= ram_q.interval;
  assign hit   = pend && due;
  // a second fired task cannot go out while the result register is stuck
  assign stall = hit && held_valid && !out_free;
  assign stop  = hit && yield_flag[chk];
  assign s_adj = yield_flag[start_index] ? wrap_inc(start_index, task_count)
                                         : start_index;

  always_comb begin
    state_next       = state;
    task_count_next  = task_count;
    start_index_next = start_index;
    id_counter_next  = id_counter;
    yield_flag_next  = yield_flag;
    pend_next        = pend;
    held_valid_next  = held_valid;
    cnt_next         = cnt;
    rp_next          = rp;
    chk_next         = chk;
    wp_next          = wp;
    held_id_next     = held_id;
    rep_status_next  = rep_status;
    rep_id_next      = rep_id;
    cur_kind_next    = cur_kind;
    cur_tid_next     = cur_tid;
    cur_ival_next    = cur_ival;
    cur_now_next     = cur_now;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = ram_q;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    emit             = 1'b0;
    emit_status      = rep_status;
    emit_id          = '0;
    emit_last        = 1'b1;
    in_ready         = 1'b0;

    case (state)
      itsch_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_kind_next = kind;
          cur_tid_next  = task_id;
          cur_ival_next = interval;
          cur_now_next  = now;
          case (kind)
            itsch_pkg::KIND_ADD: begin
              state_next = itsch_pkg::S_ADD;
            end
            itsch_pkg::KIND_DELETE, itsch_pkg::KIND_YIELD, itsch_pkg::KIND_RESUME: begin
              cnt_next   = '0;
              pend_next  = 1'b0;
              state_next = itsch_pkg::S_FIND;
            end
            itsch_pkg::KIND_TICK: begin
              if (task_count == '0) begin
                rep_status_next = itsch_pkg::ST_NONEDUE;
                rep_id_next     = '0;
                state_next      = itsch_pkg::S_REPLY;
              end else begin
                state_next = itsch_pkg::S_MOD;
              end
            end
            default: begin
              state_next = itsch_pkg::S_IDLE;
            end
          endcase
        end
      end

      itsch_pkg::S_ADD: begin
        emit = 1'b1;
        if (full) begin
          emit_status = itsch_pkg::ST_FULL;
          emit_id     = '0;
        end else begin
          emit_status = itsch_pkg::ST_ADDED;
          emit_id     = id_counter + itsch_pkg::ID_W'(1);
        end
        if (out_free) begin
          if (!full) begin
            ram_we             = 1'b1;
            ram_waddr          = task_count[IDX_W-1:0];
            ram_wdata.id       = id_counter + itsch_pkg::ID_W'(1);
            ram_wdata.interval = cur_ival;
            ram_wdata.last_run = cur_now;
            id_counter_next    = id_counter + itsch_pkg::ID_W'(1);
            task_count_next    = task_count + CNT_W'(1);
          end
          state_next = itsch_pkg::S_IDLE;
        end
      end

      itsch_pkg::S_FIND: begin
        if (match) begin
          case (cur_kind)
            itsch_pkg::KIND_DELETE: begin
              // flags above the hole move down, the vacated top clears
              for (int i = 0; i < MAX_TASKS; i++) begin
                if (i >= int'(chk)) begin
                  yield_flag_next[i] = (i + 1 < int'(task_count)) ? yield_shift[i] : 1'b0;
                end
              end
              cnt_next   = CNT_W'(chk) + CNT_W'(1);
              wp_next    = chk;
              pend_next  = 1'b0;
              state_next = itsch_pkg::S_SHIFT;
            end
            itsch_pkg::KIND_YIELD: begin
              yield_flag_next[chk] = 1'b1;
              rep_status_next      = itsch_pkg::ST_YIELDSET;
              rep_id_next          = '0;
              state_next           = itsch_pkg::S_REPLY;
            end
            default: begin
              yield_flag_next[chk] = 1'b0;
              rep_status_next      = itsch_pkg::ST_RESUMED;
              rep_id_next          = ram_q.id;
              state_next           = itsch_pkg::S_REPLY;
            end
          endcase
        end else if (cnt < task_count) begin
          ram_re    = 1'b1;
          ram_raddr = cnt[IDX_W-1:0];
          chk_next  = cnt[IDX_W-1:0];
          cnt_next  = cnt + CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            rep_status_next = itsch_pkg::ST_NOTFOUND;
            rep_id_next     = '0;
            state_next      = itsch_pkg::S_REPLY;
          end
        end
      end

      itsch_pkg::S_SHIFT: begin
        // read entry k+1 one cycle, write it to entry k the next
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = wp;
          ram_wdata = ram_q;
          wp_next   = wp + IDX_W'(1);
        end
        if (cnt < task_count) begin
          ram_re    = 1'b1;
          ram_raddr = cnt[IDX_W-1:0];
          cnt_next  = cnt + CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            task_count_next = task_count - CNT_W'(1);
            rep_status_next = itsch_pkg::ST_DELETED;
            rep_id_next     = '0;
            state_next      = itsch_pkg::S_REPLY;
          end
        end
      end

      itsch_pkg::S_MOD: begin
        // start pointer may sit past the table after deletes
        if (CNT_W'(start_index) >= task_count) begin
          start_index_next = start_index - IDX_W'(task_count);
        end else begin
          start_index_next = s_adj;
          rp_next          = s_adj;
          cnt_next         = '0;
          pend_next        = 1'b0;
          held_valid_next  = 1'b0;
          state_next       = itsch_pkg::S_WALK;
        end
      end

      itsch_pkg::S_WALK: begin
        if (!stall) begin
          if (hit) begin
            ram_we             = 1'b1;
            ram_waddr          = chk;
            ram_wdata.id       = ram_q.id;
            ram_wdata.interval = ram_q.interval;
            ram_wdata.last_run = cur_now;
            // previous fired task is known not to be the final one
            if (held_valid) begin
              emit        = 1'b1;
              emit_status = itsch_pkg::ST_FIRED;
              emit_id     = held_id;
              emit_last   = 1'b0;
            end
            held_valid_next = 1'b1;
            held_id_next    = ram_q.id;
            if (yield_flag[chk]) begin
              start_index_next = wrap_inc(chk, task_count);
              state_next       = itsch_pkg::S_FIN;
            end
          end
          if (!stop && (cnt < task_count)) begin
            ram_re    = 1'b1;
            ram_raddr = rp;
            chk_next  = rp;
            rp_next   = wrap_inc(rp, task_count);
            cnt_next  = cnt + CNT_W'(1);
            pend_next = 1'b1;
          end else begin
            pend_next = 1'b0;
            if (!pend) begin
              state_next = itsch_pkg::S_FIN;
            end
          end
        end
      end

      itsch_pkg::S_FIN: begin
        emit = 1'b1;
        if (held_valid) begin
          emit_status = itsch_pkg::ST_FIRED;
          emit_id     = held_id;
        end else begin
          emit_status = itsch_pkg::ST_NONEDUE;
          emit_id     = '0;
        end
        if (out_free) begin
          held_valid_next = 1'b0;
          state_next      = itsch_pkg::S_IDLE;
        end
      end

      itsch_pkg::S_REPLY: begin
        emit        = 1'b1;
        emit_status = rep_status;
        emit_id     = rep_id;
        if (out_free) begin
          state_next = itsch_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = itsch_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= itsch_pkg::S_IDLE;
      task_count  <= '0;
      start_index <= '0;
      id_counter  <= '0;
      yield_flag  <= '0;
      pend        <= 1'b0;
      held_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      task_count  <= task_count_next;
      start_index <= start_index_next;
      id_counter  <= id_counter_next;
      yield_flag  <= yield_flag_next;
      pend        <= pend_next;
      held_valid  <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    rp         <= rp_next;
    chk        <= chk_next;
    wp         <= wp_next;
    held_id    <= held_id_next;
    rep_status <= rep_status_next;
    rep_id     <= rep_id_next;
    cur_kind   <= cur_kind_next;
    cur_tid    <= cur_tid_next;
    cur_ival   <= cur_ival_next;
    cur_now    <= cur_now_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      status    <= emit_status;
      result_id <= emit_id;
      last      <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // table never overflows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  // no yield flag survives above the live entries
  a_yield_live: assert property (@(posedge clk) disable iff (rst)
    (yield_flag >> task_count) == '0)
    else $error("yield flag set on an unused entry");

  // a write-back never lands on the entry being fetched
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("task memory read and write collide");

  // round-robin start is inside the table when a tick completes
  a_start_live: assert property (@(posedge clk) disable iff (rst)
    (state == itsch_pkg::S_FIN) |-> (CNT_W'(start_index) < task_count))
    else $error("start pointer outside the table after a tick");

  // a result beat only leaves the walk when the register can take it
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (state == itsch_pkg::S_WALK && emit) |-> out_free)
    else $error("fired result issued into a full result register");
`endif

endmodule
